// ===== src/assert_macros.svh =====
// Assertion helpers, included by the buffer core for its checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHECK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

// ===== src/cbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_pkg
// Types and fixed constants of the compacting byte buffer.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int CFG_W    = 11;
  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int FILL_W   = 11;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  // Command codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_PEEK  = 2'd2;
  localparam logic [1:0] FUNC_RESET = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [BYTE_W-1:0] data_in;
    logic [LEN_W-1:0]  length;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              has_data;
    logic              last;
    logic [LEN_W-1:0]  count;
    logic [FILL_W-1:0] readable;
    logic [FILL_W-1:0] writable;
  } result_t;

  // Result side-band from the sequencer; the byte comes from the memory.
  typedef struct packed {
    logic              valid;
    logic              has_data;
    logic              last;
    logic [LEN_W-1:0]  count;
    logic [FILL_W-1:0] readable;
    logic [FILL_W-1:0] writable;
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BURST = 4'b0010,
    ST_COPY  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

endpackage

// ===== src/compacting_byte_buffer_core.sv =====
`timescale 1ns / 1ps
// Compacting byte buffer. Results cannot be stalled: each one is on the result
// ports for one cycle with result_valid high and must be taken then. A write,
// a position reset, or a read/peek with nothing to return leaves busy low, so
// the next command can follow at once; its single result appears the cycle
// after. A read or peek of n bytes holds busy while its burst runs, one memory
// read per cycle, and the results stream out one per cycle once the first read
// word is registered. When a read leaves the read position above half the size
// and m unread bytes remain (m nonzero), they are moved to the front through
// the single memory in a copy state and a drain state after the last byte. No
// clearing pass follows reset. The size register is written on the cfg channel
// while busy is low.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// compacting_byte_buffer_core
// Top level: size register, byte memory, sequencer and result register.
// ----------------------------------------------------------------------------
module compacting_byte_buffer_core
  import cbb_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  output logic             result_valid,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;

  logic [CFG_W-1:0]  size_reg;
  logic [PW-1:0]     size_use;
  emit_t             emit;
  emit_t             res;
  logic              res_valid;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Size register, written while idle
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_reg <= cfg_data;
    end
  end

  // Clamp the size to the store
  assign size_use = (CW'(size_reg) > CW'(DEPTH)) ? PW'(DEPTH) : PW'(size_reg);

  cbb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cbb_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .size_use  (size_use),
    .rdata     (ram_rdata),
    .busy      (busy),
    .emit      (emit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr)
  );

  // Hold the result side-band in step with the memory read word
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    res <= emit;
  end

  assign result_valid    = res_valid;
  assign result.data_out = res.has_data ? ram_rdata : '0;
  assign result.has_data = res.has_data;
  assign result.last     = res.last;
  assign result.count    = res.count;
  assign result.readable = res.readable;
  assign result.writable = res.writable;

  // Checks
  `CHECK_NEXT(a_single_result, clk, rst, start && !busy && (cmd.func == FUNC_WRITE || cmd.func == FUNC_RESET), result_valid && result.last)
  `CHECK_IMPLY(a_burst_busy, clk, rst, result_valid && !result.last, busy)
  `CHECK_IMPLY(a_empty_is_last, clk, rst, result_valid && !result.has_data, result.last)

endmodule

// ===== src/cbb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cbb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_ctrl
// Sequencer: holds the read and write positions, drives the byte memory
// for appends, read bursts and the compaction copy, and issues results.
// ----------------------------------------------------------------------------
module cbb_ctrl
  import cbb_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  cmd_t                         cmd,
  input  logic [$clog2(DEPTH+1)-1:0]   size_use,
  input  logic [BYTE_W-1:0]            rdata,
  output logic                         busy,
  output emit_t                        emit,
  output logic                         ram_we,
  output logic [$clog2(DEPTH)-1:0]     ram_waddr,
  output logic [BYTE_W-1:0]            ram_wdata,
  output logic [$clog2(DEPTH)-1:0]     ram_raddr
);

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;

  state_t        state, state_next;
  logic [PW-1:0] rp, rp_next;
  logic [PW-1:0] wp, wp_next;
  logic [1:0]    func, func_next;
  logic [BW-1:0] burst_n, burst_n_next;
  logic [BW-1:0] idx, idx_next;
  logic [AW-1:0] cp_src, cp_src_next;
  logic [PW-1:0] cp_cnt, cp_cnt_next;
  logic [PW-1:0] cp_k, cp_k_next;
  logic          pend_we;
  logic [AW-1:0] pend_addr;

  logic          accept;
  logic [PW-1:0] unread;
  logic [CW-1:0] len_sat;
  logic [CW-1:0] take;
  logic          stored;
  logic [PW-1:0] wp_inc;
  logic          last_issue;
  logic [PW-1:0] rp_adv;
  logic          compact;
  logic [PW-1:0] remain;
  logic [PW-1:0] wp_fin;
  logic [PW-1:0] rp_fin;

  // Free bytes above a write position
  function automatic logic [PW-1:0] free_of(input logic [PW-1:0] size,
                                             input logic [PW-1:0] w);
    free_of = (size > w) ? (size - w) : '0;
  endfunction

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);
  assign unread = wp - rp;

  // Saturate the request, then cut it to what is stored
  assign len_sat = (CW'(cmd.length) > CW'(MAX_BURST)) ? CW'(MAX_BURST) : CW'(cmd.length);
  assign take    = (len_sat < CW'(unread)) ? len_sat : CW'(unread);

  assign stored  = (wp < size_use);
  assign wp_inc  = wp + PW'(stored);

  // End of a burst: advance and test for compaction
  assign last_issue = ((idx + BW'(1)) == burst_n);
  assign rp_adv     = rp + PW'(burst_n);
  assign compact    = (func == FUNC_READ) && (rp_adv > (size_use >> 1));
  assign remain     = wp - rp_adv;
  assign wp_fin     = compact ? remain : wp;
  assign rp_fin     = (func == FUNC_READ) ? (compact ? '0 : rp_adv) : rp;

  always_comb begin
    state_next   = state;
    rp_next      = rp;
    wp_next      = wp;
    func_next    = func;
    burst_n_next = burst_n;
    idx_next     = idx;
    cp_src_next  = cp_src;
    cp_cnt_next  = cp_cnt;
    cp_k_next    = cp_k;
    emit         = '0;
    ram_we       = pend_we;
    ram_waddr    = pend_addr;
    ram_wdata    = rdata;
    ram_raddr    = AW'(rp + PW'(idx));

    case (state)
      ST_IDLE: begin
        if (accept) begin
          emit.valid = 1'b1;
          emit.last  = 1'b1;
          case (cmd.func)
            FUNC_WRITE: begin
              // Append when below the size in use
              ram_we         = stored;
              ram_waddr      = AW'(wp);
              ram_wdata      = cmd.data_in;
              wp_next        = wp_inc;
              emit.count     = LEN_W'(stored);
              emit.readable  = FILL_W'(wp_inc - rp);
              emit.writable  = FILL_W'(free_of(size_use, wp_inc));
            end
            FUNC_RESET: begin
              rp_next        = '0;
              wp_next        = '0;
              emit.writable  = FILL_W'(size_use);
            end
            default: begin
              if (take == '0) begin
                // Nothing to return: one empty result
                emit.readable = FILL_W'(unread);
                emit.writable = FILL_W'(free_of(size_use, wp));
              end else begin
                emit         = '0;
                func_next    = cmd.func;
                burst_n_next = BW'(take);
                idx_next     = '0;
                state_next   = ST_BURST;
              end
            end
          endcase
        end
      end

      ST_BURST: begin
        // One byte read per cycle; result shows with the read word
        emit.valid    = 1'b1;
        emit.has_data = 1'b1;
        emit.last     = last_issue;
        idx_next      = idx + BW'(1);
        if (last_issue) begin
          emit.count    = LEN_W'(burst_n);
          emit.readable = FILL_W'(wp_fin - rp_fin);
          emit.writable = FILL_W'(free_of(size_use, wp_fin));
          rp_next       = rp_fin;
          wp_next       = wp_fin;
          cp_src_next   = AW'(rp_adv);
          cp_cnt_next   = remain;
          cp_k_next     = '0;
          state_next    = (compact && (remain != '0)) ? ST_COPY : ST_IDLE;
        end
      end

      ST_COPY: begin
        // Read source now, write destination in the cycle after
        ram_raddr = AW'(cp_src + AW'(cp_k));
        cp_k_next = cp_k + PW'(1);
        if (cp_k == (cp_cnt - PW'(1))) begin
          state_next = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        // Final copy write lands here
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rp      <= '0;
      wp      <= '0;
      pend_we <= 1'b0;
    end else begin
      state   <= state_next;
      rp      <= rp_next;
      wp      <= wp_next;
      pend_we <= (state == ST_COPY);
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    func      <= func_next;
    burst_n   <= burst_n_next;
    idx       <= idx_next;
    cp_src    <= cp_src_next;
    cp_cnt    <= cp_cnt_next;
    cp_k      <= cp_k_next;
    pend_addr <= AW'(cp_k);
  end

endmodule
